// ===== design/url_percent_decoder_assert.svh =====
// Assertion macros used by the checker file.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Checked outside reset only.
`define URLPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("urlpd assertion failed");

// Checked at every edge, reset included.
`define URLPD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("urlpd assertion failed");

`endif

// ===== design/urlpd_pkg.sv =====
package urlpd_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LO_A    = 8'h61;
    localparam logic [7:0] CHAR_LO_F    = 8'h66;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;
    // digit value = byte - offset
    localparam logic [7:0] LO_HEX_OFFSET = 8'h57;
    localparam logic [7:0] UP_HEX_OFFSET = 8'h37;

    typedef enum logic [2:0] {
        PH_PLAIN  = 3'b001,
        PH_FIRST  = 3'b010,
        PH_SECOND = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] high_nibble;
    } esc_state_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_end;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'h00;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            d = ch - CHAR_ZERO;
        end else if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) begin
            d = ch - LO_HEX_OFFSET;
        end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
            d = ch - UP_HEX_OFFSET;
        end
        return d[3:0];
    endfunction

endpackage

// ===== design/urlpd_decode.sv =====
module urlpd_decode (
    input  urlpd_pkg::esc_state_t state,
    input  logic [7:0]            in_byte,
    input  logic                  end_of_text,
    input  logic                  plus_to_space,
    output urlpd_pkg::esc_state_t state_next,
    output urlpd_pkg::result_t    result
);

    logic [3:0] digit;
    logic [7:0] escaped;

    assign digit   = urlpd_pkg::hex_value(in_byte);
    assign escaped = {state.high_nibble, digit};

    always_comb begin
        state_next         = state;
        result.out_valid   = 1'b0;
        result.out_byte    = 8'h00;
        result.out_end     = end_of_text;
        unique case (state.phase)
            urlpd_pkg::PH_FIRST: begin
                state_next.high_nibble = digit;
                state_next.phase = end_of_text ? urlpd_pkg::PH_PLAIN : urlpd_pkg::PH_SECOND;
            end
            urlpd_pkg::PH_SECOND: begin
                // an escape that decodes to zero leaves out_valid low
                result.out_valid = (escaped != 8'h00);
                result.out_byte  = escaped;
                state_next.phase = urlpd_pkg::PH_PLAIN;
            end
            default: begin
                if (in_byte == urlpd_pkg::CHAR_PERCENT) begin
                    state_next.phase = end_of_text ? urlpd_pkg::PH_PLAIN
                                                   : urlpd_pkg::PH_FIRST;
                end else begin
                    result.out_valid = 1'b1;
                    result.out_byte  = (plus_to_space && in_byte == urlpd_pkg::CHAR_PLUS)
                                       ? urlpd_pkg::CHAR_SPACE : in_byte;
                    state_next.phase = urlpd_pkg::PH_PLAIN;
                end
            end
        endcase
    end

endmodule

// ===== design/url_percent_decoder.sv =====
// Channel  Direction  Ports                         Word
// s_       in         s_tvalid s_tready s_tdata     tdata[7:0] in_byte, tlast end_of_text
//                     s_tlast
// m_       out        m_tvalid m_tready m_tdata     tdata[7:0] out_byte, tuser[0] out_valid,
//                     m_tuser m_tlast               tlast out_end
// cfg_     in         cfg_valid cfg_ready cfg_data  plus_to_space
//
// One word in, one word out, one cycle per word unless m_tready stalls. Results
// are registered in the main register; a skid register behind the output keeps
// s_tready high for one more word while m_tready is low, so s_tready is registered.
// Synchronous active-low reset clears the escape state, output valids and sets
// plus_to_space. cfg_ready is always high.
module url_percent_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] out_valid
    output logic       m_tlast,   // out_end
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    urlpd_pkg::esc_state_t state_reg, state_next;
    urlpd_pkg::result_t    result;
    urlpd_pkg::result_t    main_reg, skid_reg;
    logic                  main_valid_reg, skid_valid_reg;
    logic                  plus_reg;
    logic                  accept, take;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign take      = main_valid_reg && m_tready;

    urlpd_decode u_decode (
        .state         (state_reg),
        .in_byte       (s_tdata),
        .end_of_text   (s_tlast),
        .plus_to_space (plus_reg),
        .state_next    (state_next),
        .result        (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plus_reg <= 1'b1;
        end else if (cfg_valid) begin
            plus_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= urlpd_pkg::PH_PLAIN;
            state_reg.high_nibble <= 4'h0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || take) begin
            main_valid_reg <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || take) begin
            main_reg <= skid_valid_reg ? skid_reg : result;
        end else if (accept) begin
            skid_reg <= result;
        end
    end

    assign m_tvalid   = main_valid_reg;
    assign m_tdata    = main_reg.out_byte;
    assign m_tuser[0] = main_reg.out_valid;
    assign m_tlast    = main_reg.out_end;

endmodule

// ===== design/urlpd_checker.sv =====
`include "url_percent_decoder_assert.svh"

module urlpd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    `URLPD_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid)
    `URLPD_ASSERT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
    `URLPD_ASSERT(a_empty_word_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
    `URLPD_ASSERT(a_stall_means_full, aclk, aresetn, !s_tready |-> m_tvalid)

endmodule

bind url_percent_decoder urlpd_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
